// ===== rtl/asrp_pkg.sv =====
// ============================================================================
// asrp_pkg
// Shared types, constants and helpers for the audio sample ring packetizer.
// ============================================================================
package asrp_pkg;

    // Default sizes, used as the defaults of the top level parameters.
    localparam int RING_DEPTH_DEF     = 2048;
    localparam int PACKET_SAMPLES_DEF = 48;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W   = 16;
    localparam int WORDS_W    = 7;
    localparam int BYTES_W    = 8;
    localparam int VOL_W      = 7;
    localparam int CFG_DATA_W = 7;
    localparam int RAW_W      = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    // Largest packet in words; larger requests are clipped to this.
    localparam logic [WORDS_W-1:0] MAX_WORDS = 7'd64;

    // Register reset values.
    localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd50;
    localparam logic             MUTE_RESET   = 1'b1;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Reciprocal of 100 scaled by 2^29; exact floor for magnitudes below 2^22.
    localparam int               RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
    localparam int               RECIP_SHIFT = 29;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_REQUEST = 2'd1,
        FUNC_START   = 2'd2,
        FUNC_STOP    = 2'd3
    } func_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_VOLUME = 1'b0,
        CFG_MUTE   = 1'b1
    } cfg_index_t;

    // One classified command, passed from the front to the back.
    typedef struct packed {
        func_t                      func;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       burst_end;
        logic [WORDS_W-1:0]         words;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_EMIT  = 2'd2
    } back_state_t;

    // Codec artifact values -1 and -32768 are replaced by silence.
    function automatic logic signed [SAMPLE_W-1:0] drop_artifact(
        input logic signed [SAMPLE_W-1:0] s
    );
        logic signed [SAMPLE_W-1:0] r;
        r = s;
        if (s == 16'shFFFF || s == 16'sh8000) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/asrp_ram.sv =====
// ============================================================================
// asrp_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ============================================================================
module asrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/asrp_front.sv =====
// ============================================================================
// asrp_front
// Input side: configuration registers, command classification and the
// two-stage sample conversion (gain multiply, then divide by 100).
// ============================================================================
module asrp_front
    import asrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    // Command to the queue
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_t                  cmd
);

    localparam int PROD_W  = 24;
    localparam int MAG_W   = 22;
    localparam int QPROD_W = MAG_W + RECIP_W;

    logic [VOL_W-1:0] volume_reg;
    logic             mute_reg;

    // Stage 1 registers: gain product.
    logic                     st1_valid_reg;
    func_t                    st1_func_reg;
    logic                     st1_zero_reg;
    logic signed [PROD_W-1:0] st1_prod_reg;
    logic                     st1_burst_reg;
    logic [WORDS_W-1:0]       st1_words_reg;

    // Stage 2 registers: magnitude quotient.
    logic                     st2_valid_reg;
    func_t                    st2_func_reg;
    logic                     st2_zero_reg;
    logic                     st2_neg_reg;
    logic [SAMPLE_W-1:0]      st2_quot_reg;
    logic                     st2_burst_reg;
    logic [WORDS_W-1:0]       st2_words_reg;

    logic                       advance;
    logic [RAW_W-1:0]           raw;
    logic [WORDS_W-1:0]         req_words;
    logic                       zero_word;
    logic signed [SAMPLE_W-1:0] s_in;
    logic signed [PROD_W-1:0]   prod;
    logic                       prod_neg;
    logic [PROD_W-1:0]          prod_mag;
    logic [QPROD_W-1:0]         quot_full;
    logic signed [SAMPLE_W-1:0] sat_sample;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= VOLUME_RESET;
            mute_reg   <= MUTE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_VOLUME: volume_reg <= cfg_data;
                CFG_MUTE:   mute_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // The pipeline moves whenever its last stage is empty or being drained.
    assign advance  = !st2_valid_reg || cmd_ready;
    assign s_tready = advance;

    // Stage 1 logic: screen invalid words, apply mute and multiply by gain.
    assign raw       = s_tdata[RAW_W-1:0];
    assign req_words = s_tdata[RAW_W +: WORDS_W];
    assign zero_word = (raw == '0) || (raw == '1);
    assign s_in      = mute_reg ? '0 : $signed(raw[RAW_W-1 -: SAMPLE_W]);
    assign prod      = s_in * $signed({1'b0, volume_reg});

    // Stage 2 logic: truncating division of the magnitude by 100.
    assign prod_neg  = st1_prod_reg < 0;
    assign prod_mag  = prod_neg ? PROD_W'(-st1_prod_reg) : PROD_W'(st1_prod_reg);
    assign quot_full = QPROD_W'(prod_mag[MAG_W-1:0]) * QPROD_W'(RECIP_100);

    // Stage 3 logic: restore sign, saturate and drop artifact values.
    always_comb begin
        if (st2_neg_reg) begin
            if (st2_quot_reg > 16'd32768) begin
                sat_sample = 16'sh8000;
            end else begin
                sat_sample = $signed(~st2_quot_reg + 16'd1);
            end
        end else begin
            if (st2_quot_reg > 16'd32767) begin
                sat_sample = 16'sh7FFF;
            end else begin
                sat_sample = $signed(st2_quot_reg);
            end
        end
    end

    assign cmd_valid     = st2_valid_reg;
    assign cmd.func      = st2_func_reg;
    assign cmd.sample    = st2_zero_reg ? '0 : drop_artifact(sat_sample);
    assign cmd.burst_end = st2_burst_reg;
    assign cmd.words     = st2_words_reg;

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else if (advance) begin
            st1_valid_reg <= s_tvalid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_func_reg  <= func_t'(s_tuser);
            st1_zero_reg  <= zero_word;
            st1_prod_reg  <= prod;
            st1_burst_reg <= s_tlast;
            st1_words_reg <= (req_words > MAX_WORDS) ? MAX_WORDS : req_words;

            st2_func_reg  <= st1_func_reg;
            st2_zero_reg  <= st1_zero_reg;
            st2_neg_reg   <= prod_neg;
            st2_quot_reg  <= quot_full[RECIP_SHIFT +: SAMPLE_W];
            st2_burst_reg <= st1_burst_reg;
            st2_words_reg <= st1_words_reg;
        end
    end

endmodule

// ===== rtl/asrp_cmd_queue.sv =====
// ============================================================================
// asrp_cmd_queue
// Short register FIFO of classified commands between the front and the back.
// ============================================================================
module asrp_cmd_queue
    import asrp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;
    logic [IDX_W-1:0] wr_ptr_inc;
    logic [IDX_W-1:0] rd_ptr_inc;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    assign wr_ptr_inc = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/asrp_back.sv =====
// ============================================================================
// asrp_back
// Execution side: sample ring, pointers, streaming state and the packet
// sequencer that drives the output register.
// ============================================================================
module asrp_back
    import asrp_pkg::*;
#(
    parameter int RING_DEPTH     = RING_DEPTH_DEF,
    parameter int PACKET_SAMPLES = PACKET_SAMPLES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Command from the queue
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int THRESH = RING_DEPTH * 3 / 4;
    localparam logic [WORDS_W-1:0] PKT_WORDS = WORDS_W'(PACKET_SAMPLES);

    back_state_t         state_reg, state_next;
    logic [PTR_W-1:0]    write_pos_reg, write_pos_next;
    logic [PTR_W-1:0]    read_pos_reg, read_pos_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                streaming_reg, streaming_next;
    logic [31:0]         underrun_total_reg, underrun_total_next;
    logic [WORDS_W-1:0]  pkt_n_reg, pkt_n_next;
    logic [WORDS_W-1:0]  take_reg, take_next;
    logic [WORDS_W-1:0]  idx_reg, idx_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic                ur_reg, ur_next;

    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  m_sample_reg;
    logic                        m_last_reg;
    logic [BYTES_W-1:0]          m_bytes_reg;
    logic                        m_ur_reg;

    logic                 ring_room;
    logic [FILL_W-1:0]    fill_after;
    logic                 forced_pkt;
    logic                 short_data;
    logic [WORDS_W-1:0]   take_calc;
    logic [PTR_W-1:0]     wp_inc;
    logic [PTR_W-1:0]     rp_inc;
    logic                 out_free;
    logic                 out_load;
    logic                 word_from_ring;
    logic                 word_last;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [PTR_W-1:0]     ram_rd_addr;
    logic [SAMPLE_W-1:0]  ram_rd_data;

    asrp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (cmd.sample),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Ring bookkeeping helpers.
    assign ring_room  = fill_reg < FILL_W'(RING_DEPTH);
    assign fill_after = ring_room ? fill_reg + 1'b1 : fill_reg;
    assign forced_pkt = cmd.burst_end && streaming_reg && (fill_after > FILL_W'(THRESH));
    assign wp_inc = (write_pos_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : write_pos_reg + 1'b1;
    assign rp_inc = (read_pos_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : read_pos_reg + 1'b1;

    // Packet setup: silence when idle or short of one packet.
    assign short_data = !streaming_reg || (fill_reg < FILL_W'(PACKET_SAMPLES));
    assign take_calc  = short_data ? '0 : ((pkt_n_reg < PKT_WORDS) ? pkt_n_reg : PKT_WORDS);

    // Word position within the packet being sent.
    assign out_free       = !m_valid_reg || m_tready;
    assign word_from_ring = idx_reg < take_reg;
    assign word_last      = (idx_reg + 1'b1) == pkt_n_reg;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.func == FUNC_REQUEST ||
                        (cmd.func == FUNC_PUSH && forced_pkt)) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                state_next = (pkt_n_reg == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && word_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic of the sequencer: queue pop, ring ports, word load.
    always_comb begin
        cmd_ready   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rp_inc;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                ram_wr_en = cmd_valid && (cmd.func == FUNC_PUSH) && ring_room;
            end
            ST_SETUP: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = read_pos_reg;
            end
            ST_EMIT: begin
                out_load  = out_free;
                ram_rd_en = out_free && word_from_ring;
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb begin
        write_pos_next      = write_pos_reg;
        read_pos_next       = read_pos_reg;
        fill_next           = fill_reg;
        streaming_next      = streaming_reg;
        underrun_total_next = underrun_total_reg;
        pkt_n_next          = pkt_n_reg;
        take_next           = take_reg;
        idx_next            = idx_reg;
        bytes_next          = bytes_reg;
        ur_next             = ur_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.func)
                        FUNC_PUSH: begin
                            if (ring_room) begin
                                write_pos_next = wp_inc;
                                fill_next      = fill_after;
                            end
                            pkt_n_next = PKT_WORDS;
                        end
                        FUNC_REQUEST: begin
                            pkt_n_next = cmd.words;
                        end
                        FUNC_START: begin
                            streaming_next = 1'b1;
                            fill_next      = '0;
                            write_pos_next = '0;
                            read_pos_next  = '0;
                        end
                        FUNC_STOP: begin
                            streaming_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SETUP: begin
                take_next  = take_calc;
                bytes_next = short_data ? {pkt_n_reg, 1'b0} : {take_calc, 1'b0};
                ur_next    = streaming_reg && short_data;
                fill_next  = fill_reg - FILL_W'(take_calc);
                idx_next   = '0;
                if (streaming_reg && short_data) begin
                    underrun_total_next = underrun_total_reg + 32'd1;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    idx_next = idx_reg + 1'b1;
                    if (word_from_ring) begin
                        read_pos_next = rp_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register valid: set on load, cleared once the transfer is taken.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            write_pos_reg      <= '0;
            read_pos_reg       <= '0;
            fill_reg           <= '0;
            streaming_reg      <= 1'b0;
            underrun_total_reg <= '0;
            pkt_n_reg          <= '0;
            take_reg           <= '0;
            idx_reg            <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            write_pos_reg      <= write_pos_next;
            read_pos_reg       <= read_pos_next;
            fill_reg           <= fill_next;
            streaming_reg      <= streaming_next;
            underrun_total_reg <= underrun_total_next;
            pkt_n_reg          <= pkt_n_next;
            take_reg           <= take_next;
            idx_reg            <= idx_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // Packet attributes and output payload.
    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        ur_reg    <= ur_next;
        if (out_load) begin
            m_sample_reg <= word_from_ring ? drop_artifact($signed(ram_rd_data)) : '0;
            m_last_reg   <= word_last;
            m_bytes_reg  <= bytes_reg;
            m_ur_reg     <= ur_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_bytes_reg, m_sample_reg};
    assign m_tuser  = m_ur_reg;
    assign m_tlast  = m_last_reg;

    // The ring never holds more samples than it has entries.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill level exceeds ring depth");

    // While sending, the word position stays inside the packet.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> (idx_reg < pkt_n_reg && take_reg <= pkt_n_reg))
        else $error("packet word position out of range");

    // The underrun count moves only in the packet setup cycle.
    a_underrun_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(underrun_total_reg) |-> $past(state_reg) == ST_SETUP)
        else $error("underrun count changed outside packet setup");

    // Loading the final word of a packet returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && word_last) |=> (state_reg == ST_IDLE && m_tlast))
        else $error("sequencer did not finish after the last word");

endmodule

// ===== rtl/audio_sample_ring_packetizer.sv =====
// ============================================================================
// audio_sample_ring_packetizer
// Converts I2S words into gain-scaled 16-bit samples, keeps them in a ring
// and sends them out as packets on request or when a burst end leaves the ring over 3/4 full.
//
//   Channel  Direction  Transfer when          Contents
//   s_       in         s_tvalid & s_tready    command, raw word, burst end, size
//   m_       out        m_tvalid & m_tready    packet word, byte count, underrun
//   cfg_     in         cfg_valid & cfg_ready  register index and value
//
// A command is taken every cycle while the converter can move. Conversion
// runs in steps: gain multiply, reciprocal divide, then saturation into
// the queue. Push, start and stop are handled in the back-end idle state;
// a request passes from idle through a setup state, then sends each word
// via the ring read port, and a forced packet follows its push the same way.
// Reset clears pointers, fill level, streaming and the queue; ring contents
// are not cleared. A stalled output fills the four-entry command queue and
// both conversion stages, after which s_tready drops.
// ============================================================================
module audio_sample_ring_packetizer
    import asrp_pkg::*;
#(
    parameter int RING_DEPTH     = RING_DEPTH_DEF,
    parameter int PACKET_SAMPLES = PACKET_SAMPLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // raw_word[31:0], request_words[38:32]
    input  logic [1:0]            s_tuser,   // func[1:0]
    input  logic                  s_tlast,   // burst_end
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // sample_word[15:0], byte_count[23:16]
    output logic                  m_tuser,   // underrun
    output logic                  m_tlast    // last_word
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    asrp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    asrp_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cmd)
    );

    asrp_back #(
        .RING_DEPTH     (RING_DEPTH),
        .PACKET_SAMPLES (PACKET_SAMPLES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sim/audio_sample_ring_packetizer_tb.sv =====
// ============================================================================
// audio_sample_ring_packetizer_tb
// Self-checking bench for the audio sample ring packetizer. A queue-fed driver
// sends commands on the input stream while a monitor compares every packet
// word against a cycle-free model of the ring, the gain stage and the packet
// builder. Directed commands cover the conversion extremes and the idle and
// underrun answers. A fill sequence loads more than one packet and drains it
// down into underrun. Random traffic then runs under several gain and mute
// settings, with random stalls on both stream sides.
// ============================================================================
module audio_sample_ring_packetizer_tb;
    import asrp_pkg::*;

    localparam int RING_SIZE    = RING_DEPTH_DEF;
    localparam int PKT_WORDS    = PACKET_SAMPLES_DEF;
    localparam int BURST_LEVEL  = RING_SIZE * 3 / 4;
    localparam int REST_CYCLES  = 40;
    localparam int DRAIN_GUARD  = 200000;

    // One command as the driver sends it.
    typedef struct {
        func_t       func;
        logic [31:0] raw;
        logic        burst;
        logic [6:0]  words;
    } audio_cmd_t;

    // One packet word as the block should return it.
    typedef struct {
        logic signed [15:0] sample;
        logic               is_last;
        logic [7:0]         byte_cnt;
        logic               underrun;
    } packet_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // raw_word[31:0], request_words[38:32]
    logic [1:0]            s_tuser;   // func[1:0]
    logic                  s_tlast;   // burst_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // sample_word[15:0], byte_count[23:16]
    logic                  m_tuser;   // underrun
    logic                  m_tlast;   // last_word

    audio_cmd_t   cmd_q[$];
    packet_word_t expected_words[$];
    bit           steady;
    int           error_count;
    int           cmds_sent;
    int           cmds_offered;
    int           words_checked;
    int           forced_packets;
    int           underrun_packets;

    // Model state of the ring and its controls.
    logic [15:0]  ring_model [RING_SIZE];
    logic [10:0]  wr_ptr       = '0;
    logic [10:0]  rd_ptr       = '0;
    int unsigned  fill_cnt     = 0;
    logic         stream_on    = 1'b0;
    logic [31:0]  underrun_cnt = '0;
    logic [6:0]   vol_model;
    logic         mute_model;

    audio_sample_ring_packetizer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #3000000;
        $display("audio_sample_ring_packetizer_tb: errors");
        $finish;
    end

    // Codec artifact values read as silence.
    function automatic logic signed [15:0] kill_artifact(logic signed [15:0] s);
        if (s == 16'shFFFF || s == 16'sh8000) begin
            return 16'sd0;
        end
        return s;
    endfunction

    // Raw I2S word to a gain-scaled sample.
    function automatic logic signed [15:0] scale_sample(logic [31:0] raw);
        int s;
        int p;
        if (raw == 32'd0 || raw == 32'hFFFF_FFFF) begin
            return 16'sd0;
        end
        s = int'($signed(raw[31:16]));
        if (mute_model) begin
            s = 0;
        end
        p = (s * int'(vol_model)) / 100;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return kill_artifact(16'(p));
    endfunction

    // Drain one packet from the model ring, or answer with silence.
    function automatic void build_packet(int unsigned words);
        int unsigned        n;
        int unsigned        take;
        int unsigned        bytes;
        logic               ur;
        logic signed [15:0] s;
        packet_word_t       w;
        n    = (words > 64) ? 64 : words;
        take = 0;
        ur   = 1'b0;
        if (!stream_on || fill_cnt < PKT_WORDS) begin
            if (stream_on) begin
                underrun_cnt = underrun_cnt + 32'd1;
                ur = 1'b1;
            end
            bytes = 2 * n;
        end else begin
            take = (n < PKT_WORDS) ? n : PKT_WORDS;
            if (take > fill_cnt) take = fill_cnt;
            bytes = 2 * take;
        end
        for (int i = 0; i < n; i++) begin
            s = 16'sd0;
            if (i < take) begin
                s = ring_model[rd_ptr];
                rd_ptr = rd_ptr + 11'd1;
                fill_cnt = fill_cnt - 1;
                s = kill_artifact(s);
            end
            w.sample   = s;
            w.is_last  = (i + 1 == n);
            w.byte_cnt = 8'(bytes);
            w.underrun = ur;
            expected_words.push_back(w);
        end
        if (ur && n != 0) underrun_packets++;
    endfunction

    // Apply one accepted command to the model.
    function automatic void predict_command(audio_cmd_t c);
        logic signed [15:0] s;
        case (c.func)
            FUNC_PUSH: begin
                s = scale_sample(c.raw);
                if (fill_cnt < RING_SIZE) begin
                    ring_model[wr_ptr] = s;
                    wr_ptr = wr_ptr + 11'd1;
                    fill_cnt = fill_cnt + 1;
                end
                if (c.burst && stream_on && fill_cnt > BURST_LEVEL) begin
                    forced_packets++;
                    build_packet(PKT_WORDS);
                end
            end
            FUNC_REQUEST: begin
                build_packet(32'(c.words));
            end
            FUNC_START: begin
                stream_on = 1'b1;
                fill_cnt  = 0;
                wr_ptr    = '0;
                rd_ptr    = '0;
            end
            default: begin
                stream_on = 1'b0;
            end
        endcase
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 11);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0h want %0h at word %0d", what, got, want,
                 words_checked);
        error_count++;
    endtask

    task automatic queue_cmd(func_t f, logic [31:0] raw, logic burst, logic [6:0] words);
        audio_cmd_t c;
        c.func  = f;
        c.raw   = raw;
        c.burst = burst;
        c.words = words;
        cmd_q.push_back(c);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(cfg_index_t idx, logic [6:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_VOLUME) vol_model = val;
        else mute_model = val[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every command went in and every expected word came out.
    task automatic drain_and_rest();
        while (cmd_q.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (REST_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return {16'hFFFF, 16'($urandom)};
            3: return {16'h8000, 16'($urandom)};
            4: return {16'h7FFF, 16'($urandom)};
            5: return {16'(int'($urandom_range(4)) - 2), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] pick_words();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 7'd0;
        if (r < 12) return 7'($urandom_range(127, 65));
        return 7'($urandom_range(64, 1));
    endfunction

    // Mostly pushes with requests mixed in, the odd start or stop.
    task automatic run_mix(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 80)
                queue_cmd(FUNC_PUSH, pick_raw(), ($urandom_range(9) == 0), 7'($urandom));
            else if (r < 93)
                queue_cmd(FUNC_REQUEST, $urandom, 1'($urandom), pick_words());
            else if (r < 96)
                queue_cmd(FUNC_START, $urandom, 1'($urandom), 7'($urandom));
            else
                queue_cmd(FUNC_STOP, $urandom, 1'($urandom), 7'($urandom));
        end
    endtask

    // Load more than one packet, take a full one, then run short.
    task automatic fill_ring();
        queue_cmd(FUNC_START, 32'd0, 1'b0, 7'd0);
        for (int i = 1; i <= 64; i++) begin
            queue_cmd(FUNC_PUSH, pick_raw(), (i == 10 || i == 64), 7'd0);
        end
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd64);
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd1);
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd48);
    endtask

    // Accept side of the input stream: predict on each transfer.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_command(cmd_q.pop_front());
            cmds_sent++;
        end
    end

    // Driver: hold a command until it transfers, idle now and then.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= FUNC_PUSH;
            s_tlast  <= 1'b0;
        end else if (cmds_sent == cmds_offered) begin
            if (cmd_q.size() != 0 && !take_break()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, cmd_q[0].words, cmd_q[0].raw};
                s_tuser  <= cmd_q[0].func;
                s_tlast  <= cmd_q[0].burst;
                cmds_offered++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(negedge aclk) begin
        m_tready <= !take_break();
    end

    // Monitor: compare each output transfer with the oldest expected word.
    always @(posedge aclk) begin
        packet_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing expected", 32'(m_tdata), 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[15:0] !== want.sample)
                    report_mismatch("sample_word", 32'(m_tdata[15:0]),
                                    32'($unsigned(want.sample)));
                if (m_tdata[23:16] !== want.byte_cnt)
                    report_mismatch("byte_count", 32'(m_tdata[23:16]),
                                    32'(want.byte_cnt));
                if (m_tlast !== want.is_last)
                    report_mismatch("last_word", 32'(m_tlast), 32'(want.is_last));
                if (m_tuser !== want.underrun)
                    report_mismatch("underrun", 32'(m_tuser), 32'(want.underrun));
            end
            words_checked++;
        end
    end

    // Main sequence.
    initial begin
        logic [6:0] vol_set [7];
        logic       mute_set [7];
        int         guard;

        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_VOLUME;
        cfg_data   = '0;
        steady     = 1'b0;
        vol_model  = VOLUME_RESET;
        mute_model = MUTE_RESET;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: idle request, muted pushes.
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd10);
        queue_cmd(FUNC_PUSH, 32'h7FFF_0000, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'h1234_0000, 1'b1, 7'd0);
        drain_and_rest();

        // Unity gain: underrun answers and conversion extremes.
        write_reg(CFG_VOLUME, 7'd100);
        write_reg(CFG_MUTE, 7'd0);
        queue_cmd(FUNC_START, 32'd0, 1'b0, 7'd0);
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd5);
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd0);
        queue_cmd(FUNC_REQUEST, 32'hFFFF_FFFF, 1'b1, 7'd127);
        queue_cmd(FUNC_PUSH, 32'd0, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'hFFFF_FFFF, 1'b1, 7'd0);
        queue_cmd(FUNC_PUSH, 32'h8000_1234, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'hFFFF_0001, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'h7FFF_FFFF, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'h8001_0000, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'h0001_0000, 1'b0, 7'd0);
        queue_cmd(FUNC_PUSH, 32'hFFFE_0000, 1'b1, 7'd0);
        queue_cmd(FUNC_STOP, 32'd0, 1'b0, 7'd0);
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd64);
        queue_cmd(FUNC_REQUEST, 32'd0, 1'b0, 7'd1);
        drain_and_rest();

        // Fill with no idling on either side.
        steady = 1'b1;
        fill_ring();
        drain_and_rest();
        steady = 1'b0;

        // Random traffic under a range of gain and mute settings.
        vol_set[0] = 7'd100;                    mute_set[0] = 1'b0;
        vol_set[1] = 7'd0;                      mute_set[1] = 1'b0;
        vol_set[2] = 7'd127;                    mute_set[2] = 1'b0;
        vol_set[3] = 7'd1;                      mute_set[3] = 1'b0;
        vol_set[4] = 7'($urandom_range(99, 2)); mute_set[4] = 1'b0;
        vol_set[5] = 7'($urandom);              mute_set[5] = 1'b1;
        vol_set[6] = 7'd50;                     mute_set[6] = 1'b0;
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_VOLUME, vol_set[ph]);
            write_reg(CFG_MUTE, {6'd0, mute_set[ph]});
            if (ph == 0) queue_cmd(FUNC_START, 32'd0, 1'b0, 7'd0);
            run_mix(24);
            if (ph == 6) break;
            drain_and_rest();
        end

        // Final drain with a bound, then a quiet tail.
        guard = 0;
        while ((cmd_q.size() != 0 || s_tvalid || expected_words.size() != 0)
               && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (REST_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0)
            report_mismatch("words never delivered", expected_words.size(), 32'd0);

        $display("covered %0d commands and %0d packet words", cmds_sent, words_checked);
        $display("forced packets %0d, underrun packets %0d (%0d counted), mismatches %0d",
                 forced_packets, underrun_packets, underrun_cnt, error_count);
        if (error_count == 0) begin
            $display("audio_sample_ring_packetizer_tb: clean");
        end else begin
            $display("audio_sample_ring_packetizer_tb: errors");
        end
        $finish;
    end

endmodule
